// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants of the prime field arithmetic unit.
`default_nettype none

package pfa_pkg;

    // Fixed field widths of the transaction payloads
    localparam int FIELD_W = 31;
    localparam int CMD_W   = 3;

    // Modulus after reset (largest 31-bit prime)
    localparam logic [FIELD_W-1:0] MOD_RESET = 31'h7FFF_FFFF;

    // Operation codes carried in the cmd field
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEG    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MULSUB = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INV    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DIV    = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] op_a;
        logic [FIELD_W-1:0] op_b;
        logic [FIELD_W-1:0] op_c;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               div_by_zero;
        logic               result_is_zero;
    } out_item_t;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_INIT,
        DP_DIV_ALIGN,
        DP_DIV_STEP,
        DP_RED_WB,
        DP_EUC_INIT,
        DP_EUC_SHIFT,
        DP_EUC_UPD,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_RES
    } dp_op_t;

    // Operand register picked by divide, writeback and Euclid init
    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_F1
    } src_sel_t;

    // Multiplicand / multiplier pairs
    typedef enum logic [1:0] {
        MUL_AB,
        MUL_S2Q,
        MUL_AS2
    } mul_sel_t;

    // Value written to the output register
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_ADD,
        RES_SUB,
        RES_NEG,
        RES_ACC,
        RES_C_MINUS_ACC,
        RES_C,
        RES_S2
    } res_sel_t;

    typedef struct packed {
        dp_op_t   op;
        src_sel_t src;
        mul_sel_t msel;
        res_sel_t rsel;
        logic     dz;
    } dp_cmd_t;

    typedef struct packed {
        logic align_ok;
        logic k_zero;
        logic rem_zero;
        logic mul_done;
        logic a_zero;
        logic b_zero;
        logic p_small;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED,
        ST_DIV_ALIGN,
        ST_DIV_STEP,
        ST_RED_WB,
        ST_DISPATCH,
        ST_MUL,
        ST_EUC_DIV,
        ST_EUC_SHIFT,
        ST_EUC_MUL,
        ST_EUC_UPD,
        ST_DIV_MUL,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/prime_field_alu.sv =====
// Top level of the GF(p) arithmetic unit: controller plus datapath.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    pfa_pkg::in_item_t  (cmd, op_a, op_b, op_c)
//   m_       out  m_valid/m_ready    pfa_pkg::out_item_t (result, div_by_zero,
//                                                         result_is_zero)
//   cfg_     in   cfg_wr_en          cfg_wr_data = modulus
//
// One transaction at a time. Operands are first reduced by a shift-subtract
// divider. mul/mulsub then run a serial multiply over the significant bits
// of the reduced op_b. inv/div run Euclid rounds, each a shift-subtract divide
// plus, while the remainder is nonzero, a serial multiply by the quotient.
// Reset is synchronous, active low, and loads modulus 2^31-1.
// A new transaction is taken while a finished result waits on m_; the
// following result holds in the controller until m_ is free.
`default_nettype none

module prime_field_alu #(
    parameter int WIDTH = 31
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pfa_pkg::FIELD_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire pfa_pkg::in_item_t             s_payload,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output pfa_pkg::out_item_t                 m_payload
);

    pfa_pkg::dp_cmd_t  dp_cmd;
    pfa_pkg::dp_stat_t dp_stat;

    pfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_payload.cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    pfa_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_payload   (s_payload),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .m_payload   (m_payload)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_datapath.sv =====
// Datapath: operand registers, shift-subtract divider, serial modular multiplier.
`default_nettype none

module pfa_datapath #(
    parameter int WIDTH = 31
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pfa_pkg::FIELD_W-1:0]   cfg_wr_data,
    input  wire pfa_pkg::in_item_t             s_payload,
    input  wire pfa_pkg::dp_cmd_t              dp_cmd,
    output pfa_pkg::dp_stat_t                  dp_stat,
    output pfa_pkg::out_item_t                 m_payload
);

    localparam int FW = pfa_pkg::FIELD_W;
    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0] p_reg;
    logic [WIDTH-1:0] ra_reg, rb_reg, rc_reg;
    logic [WIDTH-1:0] f1_reg, f2_reg, s1_reg, s2_reg;
    logic [WIDTH-1:0] num_reg, den_reg, q_reg;
    logic [KW-1:0]    k_reg;
    logic [WIDTH-1:0] acc_reg, mc_reg, ml_reg;
    pfa_pkg::out_item_t out_reg;

    logic [WIDTH-1:0] div_src;
    logic             div_ge;
    logic [WIDTH-1:0] res_val;

    // (x + y) mod p for x, y below p
    function automatic logic [WIDTH-1:0] mod_add(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] p);
        logic [WIDTH:0] s;
        logic [WIDTH:0] t;
        s = {1'b0, x} + {1'b0, y};
        t = s - {1'b0, p};
        return (s >= {1'b0, p}) ? t[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

    // (x - y) mod p for x, y below p; wraps through 2^WIDTH
    function automatic logic [WIDTH-1:0] mod_sub(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] p);
        return (x >= y) ? (x - y) : (x - y + p);
    endfunction

    // Modulus register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= WIDTH'(pfa_pkg::MOD_RESET);
        end else if (cfg_wr_en) begin
            p_reg <= WIDTH'(cfg_wr_data);
        end
    end

    // Select dividend for a divide
    always_comb begin
        unique case (dp_cmd.src)
            pfa_pkg::SRC_A:  div_src = ra_reg;
            pfa_pkg::SRC_B:  div_src = rb_reg;
            pfa_pkg::SRC_C:  div_src = rc_reg;
            pfa_pkg::SRC_F1: div_src = f1_reg;
        endcase
    end

    assign div_ge = (num_reg >= den_reg);

    // Select result value
    always_comb begin
        unique case (dp_cmd.rsel)
            pfa_pkg::RES_ZERO:        res_val = '0;
            pfa_pkg::RES_ADD:         res_val = mod_add(ra_reg, rb_reg, p_reg);
            pfa_pkg::RES_SUB:         res_val = mod_sub(ra_reg, rb_reg, p_reg);
            pfa_pkg::RES_NEG:         res_val = mod_sub('0, ra_reg, p_reg);
            pfa_pkg::RES_ACC:         res_val = acc_reg;
            pfa_pkg::RES_C_MINUS_ACC: res_val = mod_sub(rc_reg, acc_reg, p_reg);
            pfa_pkg::RES_C:           res_val = rc_reg;
            pfa_pkg::RES_S2:          res_val = s2_reg;
        endcase
    end

    // Execute one micro-operation
    always_ff @(posedge aclk) begin
        unique case (dp_cmd.op)
            pfa_pkg::DP_NOP: begin
            end
            pfa_pkg::DP_LOAD: begin
                ra_reg <= WIDTH'(s_payload.op_a);
                rb_reg <= WIDTH'(s_payload.op_b);
                rc_reg <= WIDTH'(s_payload.op_c);
            end
            pfa_pkg::DP_DIV_INIT: begin
                num_reg <= div_src;
                den_reg <= (dp_cmd.src == pfa_pkg::SRC_F1) ? f2_reg : p_reg;
                q_reg   <= '0;
                k_reg   <= '0;
            end
            pfa_pkg::DP_DIV_ALIGN: begin
                den_reg <= den_reg << 1;
                k_reg   <= k_reg + KW'(1);
            end
            pfa_pkg::DP_DIV_STEP: begin
                if (div_ge) begin
                    num_reg <= num_reg - den_reg;
                end
                q_reg   <= {q_reg[WIDTH-2:0], div_ge};
                den_reg <= den_reg >> 1;
                k_reg   <= k_reg - KW'(1);
            end
            pfa_pkg::DP_RED_WB: begin
                unique case (dp_cmd.src)
                    pfa_pkg::SRC_A:  ra_reg <= num_reg;
                    pfa_pkg::SRC_B:  rb_reg <= num_reg;
                    pfa_pkg::SRC_C:  rc_reg <= num_reg;
                    pfa_pkg::SRC_F1: f1_reg <= num_reg;
                endcase
            end
            pfa_pkg::DP_EUC_INIT: begin
                f1_reg <= (dp_cmd.src == pfa_pkg::SRC_B) ? rb_reg : ra_reg;
                f2_reg <= p_reg;
                s1_reg <= WIDTH'(1);
                s2_reg <= '0;
            end
            pfa_pkg::DP_EUC_SHIFT: begin
                f1_reg <= f2_reg;
                f2_reg <= num_reg;
            end
            pfa_pkg::DP_EUC_UPD: begin
                s1_reg <= s2_reg;
                s2_reg <= mod_sub(s1_reg, acc_reg, p_reg);
            end
            pfa_pkg::DP_MUL_INIT: begin
                acc_reg <= '0;
                unique case (dp_cmd.msel)
                    pfa_pkg::MUL_AB: begin
                        mc_reg <= ra_reg;
                        ml_reg <= rb_reg;
                    end
                    pfa_pkg::MUL_S2Q: begin
                        mc_reg <= s2_reg;
                        ml_reg <= q_reg;
                    end
                    default: begin
                        mc_reg <= ra_reg;
                        ml_reg <= s2_reg;
                    end
                endcase
            end
            pfa_pkg::DP_MUL_STEP: begin
                if (ml_reg[0]) begin
                    acc_reg <= mod_add(acc_reg, mc_reg, p_reg);
                end
                mc_reg <= mod_add(mc_reg, mc_reg, p_reg);
                ml_reg <= ml_reg >> 1;
            end
            pfa_pkg::DP_RES: begin
                out_reg.result         <= FW'(res_val);
                out_reg.div_by_zero    <= dp_cmd.dz;
                out_reg.result_is_zero <= (FW'(res_val) == '0);
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller
    always_comb begin
        dp_stat.align_ok = ({den_reg, 1'b0} <= {1'b0, num_reg});
        dp_stat.k_zero   = (k_reg == '0);
        dp_stat.rem_zero = (num_reg == '0);
        dp_stat.mul_done = (ml_reg == '0);
        dp_stat.a_zero   = (ra_reg == '0);
        dp_stat.b_zero   = (rb_reg == '0);
        dp_stat.p_small  = (p_reg < WIDTH'(2));
    end

    assign m_payload = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_ctrl.sv =====
// Controller: sequences reduction, Euclid rounds, multiplies and result handoff.
`default_nettype none

module pfa_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pfa_pkg::CMD_W-1:0]   s_cmd,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pfa_pkg::dp_cmd_t                 dp_cmd,
    input  wire pfa_pkg::dp_stat_t           dp_stat
);

    pfa_pkg::state_t             state_reg, state_next;
    pfa_pkg::state_t             ret_reg, ret_next;
    logic [pfa_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    pfa_pkg::src_sel_t           red_sel_reg, red_sel_next;
    pfa_pkg::res_sel_t           res_sel_reg, res_sel_next;
    logic                        dz_reg, dz_next;
    logic                        m_valid_reg, m_valid_next;

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfa_pkg::ST_IDLE;
            ret_reg     <= pfa_pkg::ST_IDLE;
            cmd_reg     <= pfa_pkg::CMD_ADD;
            red_sel_reg <= pfa_pkg::SRC_A;
            res_sel_reg <= pfa_pkg::RES_ZERO;
            dz_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            cmd_reg     <= cmd_next;
            red_sel_reg <= red_sel_next;
            res_sel_reg <= res_sel_next;
            dz_reg      <= dz_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd_next     = cmd_reg;
        red_sel_next = red_sel_reg;
        res_sel_next = res_sel_reg;
        dz_next      = dz_reg;
        m_valid_next = m_valid_reg;
        dp_cmd.op    = pfa_pkg::DP_NOP;
        dp_cmd.src   = pfa_pkg::SRC_A;
        dp_cmd.msel  = pfa_pkg::MUL_AB;
        dp_cmd.rsel  = pfa_pkg::RES_ZERO;
        dp_cmd.dz    = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    dp_cmd.op  = pfa_pkg::DP_LOAD;
                    cmd_next   = s_cmd;
                    dz_next    = 1'b0;
                    state_next = pfa_pkg::ST_CHECK;
                end
            end
            pfa_pkg::ST_CHECK: begin
                if (dp_stat.p_small) begin
                    res_sel_next = pfa_pkg::RES_ZERO;
                    dz_next      = (cmd_reg == pfa_pkg::CMD_DIV) && dp_stat.b_zero;
                    state_next   = pfa_pkg::ST_RESULT;
                end else begin
                    red_sel_next = pfa_pkg::SRC_A;
                    state_next   = pfa_pkg::ST_RED;
                end
            end
            pfa_pkg::ST_RED: begin
                dp_cmd.op  = pfa_pkg::DP_DIV_INIT;
                dp_cmd.src = red_sel_reg;
                ret_next   = pfa_pkg::ST_RED_WB;
                state_next = pfa_pkg::ST_DIV_ALIGN;
            end
            pfa_pkg::ST_DIV_ALIGN: begin
                if (dp_stat.align_ok) begin
                    dp_cmd.op = pfa_pkg::DP_DIV_ALIGN;
                end else begin
                    state_next = pfa_pkg::ST_DIV_STEP;
                end
            end
            pfa_pkg::ST_DIV_STEP: begin
                dp_cmd.op = pfa_pkg::DP_DIV_STEP;
                if (dp_stat.k_zero) begin
                    state_next = ret_reg;
                end
            end
            pfa_pkg::ST_RED_WB: begin
                dp_cmd.op  = pfa_pkg::DP_RED_WB;
                dp_cmd.src = red_sel_reg;
                unique case (red_sel_reg)
                    pfa_pkg::SRC_A: begin
                        red_sel_next = pfa_pkg::SRC_B;
                        state_next   = pfa_pkg::ST_RED;
                    end
                    pfa_pkg::SRC_B: begin
                        red_sel_next = pfa_pkg::SRC_C;
                        state_next   = pfa_pkg::ST_RED;
                    end
                    pfa_pkg::SRC_C, pfa_pkg::SRC_F1: begin
                        state_next = pfa_pkg::ST_DISPATCH;
                    end
                endcase
            end
            pfa_pkg::ST_DISPATCH: begin
                state_next = pfa_pkg::ST_RESULT;
                unique case (cmd_reg)
                    pfa_pkg::CMD_ADD: res_sel_next = pfa_pkg::RES_ADD;
                    pfa_pkg::CMD_SUB: res_sel_next = pfa_pkg::RES_SUB;
                    pfa_pkg::CMD_NEG: res_sel_next = pfa_pkg::RES_NEG;
                    pfa_pkg::CMD_MUL: begin
                        dp_cmd.op    = pfa_pkg::DP_MUL_INIT;
                        dp_cmd.msel  = pfa_pkg::MUL_AB;
                        res_sel_next = pfa_pkg::RES_ACC;
                        ret_next     = pfa_pkg::ST_RESULT;
                        state_next   = pfa_pkg::ST_MUL;
                    end
                    pfa_pkg::CMD_MULSUB: begin
                        if (dp_stat.a_zero || dp_stat.b_zero) begin
                            res_sel_next = pfa_pkg::RES_C;
                        end else begin
                            dp_cmd.op    = pfa_pkg::DP_MUL_INIT;
                            dp_cmd.msel  = pfa_pkg::MUL_AB;
                            res_sel_next = pfa_pkg::RES_C_MINUS_ACC;
                            ret_next     = pfa_pkg::ST_RESULT;
                            state_next   = pfa_pkg::ST_MUL;
                        end
                    end
                    pfa_pkg::CMD_INV: begin
                        dp_cmd.op  = pfa_pkg::DP_EUC_INIT;
                        dp_cmd.src = pfa_pkg::SRC_A;
                        state_next = pfa_pkg::ST_EUC_DIV;
                    end
                    pfa_pkg::CMD_DIV: begin
                        if (dp_stat.b_zero) begin
                            res_sel_next = pfa_pkg::RES_ZERO;
                            dz_next      = 1'b1;
                        end else if (dp_stat.a_zero) begin
                            res_sel_next = pfa_pkg::RES_ZERO;
                        end else begin
                            dp_cmd.op  = pfa_pkg::DP_EUC_INIT;
                            dp_cmd.src = pfa_pkg::SRC_B;
                            state_next = pfa_pkg::ST_EUC_DIV;
                        end
                    end
                    default: res_sel_next = pfa_pkg::RES_ZERO;
                endcase
            end
            pfa_pkg::ST_MUL: begin
                if (dp_stat.mul_done) begin
                    state_next = ret_reg;
                end else begin
                    dp_cmd.op = pfa_pkg::DP_MUL_STEP;
                end
            end
            pfa_pkg::ST_EUC_DIV: begin
                dp_cmd.op  = pfa_pkg::DP_DIV_INIT;
                dp_cmd.src = pfa_pkg::SRC_F1;
                ret_next   = pfa_pkg::ST_EUC_SHIFT;
                state_next = pfa_pkg::ST_DIV_ALIGN;
            end
            pfa_pkg::ST_EUC_SHIFT: begin
                dp_cmd.op = pfa_pkg::DP_EUC_SHIFT;
                if (!dp_stat.rem_zero) begin
                    state_next = pfa_pkg::ST_EUC_MUL;
                end else if (cmd_reg == pfa_pkg::CMD_INV) begin
                    res_sel_next = pfa_pkg::RES_S2;
                    state_next   = pfa_pkg::ST_RESULT;
                end else begin
                    state_next = pfa_pkg::ST_DIV_MUL;
                end
            end
            pfa_pkg::ST_EUC_MUL: begin
                dp_cmd.op   = pfa_pkg::DP_MUL_INIT;
                dp_cmd.msel = pfa_pkg::MUL_S2Q;
                ret_next    = pfa_pkg::ST_EUC_UPD;
                state_next  = pfa_pkg::ST_MUL;
            end
            pfa_pkg::ST_EUC_UPD: begin
                dp_cmd.op  = pfa_pkg::DP_EUC_UPD;
                state_next = pfa_pkg::ST_EUC_DIV;
            end
            pfa_pkg::ST_DIV_MUL: begin
                dp_cmd.op    = pfa_pkg::DP_MUL_INIT;
                dp_cmd.msel  = pfa_pkg::MUL_AS2;
                res_sel_next = pfa_pkg::RES_ACC;
                ret_next     = pfa_pkg::ST_RESULT;
                state_next   = pfa_pkg::ST_MUL;
            end
            pfa_pkg::ST_RESULT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.op    = pfa_pkg::DP_RES;
                    dp_cmd.rsel  = res_sel_reg;
                    dp_cmd.dz    = dz_reg;
                    m_valid_next = 1'b1;
                    state_next   = pfa_pkg::ST_IDLE;
                end
            end
            default: state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == pfa_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_checker.sv =====
// Port-level checks of the GF(p) arithmetic unit, bound to the top level.
`default_nettype none

module pfa_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pfa_pkg::out_item_t m_payload
);

    // No result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed or dropped");

    // Zero flag agrees with the result value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.result_is_zero == (m_payload.result == '0)))
        else $error("result_is_zero mismatch");

    // Division by zero returns zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.div_by_zero |-> (m_payload.result == '0)
            && m_payload.result_is_zero)
        else $error("div_by_zero with nonzero result");

endmodule

bind prime_field_alu pfa_checker u_pfa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

// ===== sim/pfa_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the GF(p) arithmetic unit: predicts every result and compares it.
module pfa_scoreboard (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pfa_pkg::FIELD_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  pfa_pkg::in_item_t             s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  pfa_pkg::out_item_t            m_payload,
    output int                            mismatches,
    output int                            pending,
    output int                            checked
);

    localparam int MAX_REPORTS = 10;

    // One outstanding operation: what went in, under which modulus, what must come out
    typedef struct packed {
        pfa_pkg::in_item_t           op;
        logic [pfa_pkg::FIELD_W-1:0] modv;
        pfa_pkg::out_item_t          want;
    } field_op_t;

    field_op_t                   expected_results [$];
    logic [pfa_pkg::FIELD_W-1:0] field_modulus = pfa_pkg::MOD_RESET;
    int                          fail_count    = 0;
    int                          check_count   = 0;

    // (x - y) mod p for x, y already reduced
    function automatic longint unsigned field_sub(longint unsigned x, longint unsigned y,
                                                  longint unsigned p);
        return (x >= y) ? (x - y) : (x + p - y);
    endfunction

    // Extended Euclid on (x, p); zero maps to zero
    function automatic longint unsigned field_inverse(longint unsigned x, longint unsigned p);
        longint unsigned f1, f2, s1, s2, q, rem, t;
        f1 = x;
        f2 = p;
        s1 = 1;
        s2 = 0;
        q   = f1 / f2;
        rem = f1 - f2 * q;
        f1  = f2;
        f2  = rem;
        while (f2 != 0) begin
            t   = field_sub(s1 % p, (s2 * q) % p, p);
            s1  = s2;
            s2  = t;
            q   = f1 / f2;
            rem = f1 - f2 * q;
            f1  = f2;
            f2  = rem;
        end
        return s2 % p;
    endfunction

    // Compute the result of one operation under the given modulus
    function automatic pfa_pkg::out_item_t field_result(pfa_pkg::in_item_t it,
                                                        logic [pfa_pkg::FIELD_W-1:0] modv);
        longint unsigned    p, a, b, c, res;
        logic               dz;
        pfa_pkg::out_item_t r;
        p   = 64'(modv);
        res = 0;
        dz  = 1'b0;
        if (p < 2) begin
            // degenerate field: only the raw zero divisor is still flagged
            dz = (it.cmd == pfa_pkg::CMD_DIV) && (it.op_b == '0);
        end else begin
            a = 64'(it.op_a);
            b = 64'(it.op_b);
            c = 64'(it.op_c);
            a = a % p;
            b = b % p;
            c = c % p;
            case (it.cmd)
                pfa_pkg::CMD_ADD:    res = (a + b) % p;
                pfa_pkg::CMD_SUB:    res = field_sub(a, b, p);
                pfa_pkg::CMD_NEG:    res = field_sub(0, a, p);
                pfa_pkg::CMD_MUL:    res = (a * b) % p;
                pfa_pkg::CMD_MULSUB: begin
                    res = (a == 0 || b == 0) ? c : field_sub(c, (a * b) % p, p);
                end
                pfa_pkg::CMD_INV:    res = field_inverse(a, p);
                pfa_pkg::CMD_DIV: begin
                    if (b == 0) begin
                        dz = 1'b1;
                    end else if (a != 0) begin
                        res = (a * field_inverse(b, p)) % p;
                    end
                end
                default:             res = 0;
            endcase
        end
        r.result         = res[pfa_pkg::FIELD_W-1:0];
        r.div_by_zero    = dz;
        r.result_is_zero = (res[pfa_pkg::FIELD_W-1:0] == '0);
        return r;
    endfunction

    // Track the modulus, queue predictions, retire results in order
    always @(posedge aclk) begin : scoreboard
        field_op_t head;
        if (!aresetn) begin
            field_modulus = pfa_pkg::MOD_RESET;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                field_modulus = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("[%0t] unexpected result: result=%0d dz=%b zero=%b",
                                 $realtime, m_payload.result, m_payload.div_by_zero,
                                 m_payload.result_is_zero);
                    end
                    fail_count++;
                end else begin
                    head = expected_results.pop_front();
                    check_count++;
                    if ((m_payload.result !== head.want.result) ||
                        (m_payload.div_by_zero !== head.want.div_by_zero) ||
                        (m_payload.result_is_zero !== head.want.result_is_zero)) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("[%0t] mismatch: cmd=%0d a=%h b=%h c=%h p=%0d",
                                     $realtime, head.op.cmd, head.op.op_a, head.op.op_b,
                                     head.op.op_c, head.modv);
                            $display("    expected result=%0d dz=%b zero=%b,",
                                     head.want.result, head.want.div_by_zero,
                                     head.want.result_is_zero);
                            $display("    got result=%0d dz=%b zero=%b",
                                     m_payload.result, m_payload.div_by_zero,
                                     m_payload.result_is_zero);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back({s_payload, field_modulus,
                                            field_result(s_payload, field_modulus)});
            end
        end
        pending    <= expected_results.size();
        mismatches <= fail_count;
        checked    <= check_count;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the GF(p) arithmetic unit test: clock, reset, stimulus, verdict.
module testbench;

    localparam int                          IDLE_LIMIT   = 20000;
    localparam int                          DRAIN_CYCLES = 600;
    localparam int                          NUM_MODULI   = 14;
    localparam logic [pfa_pkg::CMD_W-1:0]   CMD_UNUSED   = 3'd7;
    localparam logic [pfa_pkg::FIELD_W-1:0] ALL_ONES     = '1;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [pfa_pkg::FIELD_W-1:0] cfg_wr_data = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    pfa_pkg::in_item_t           s_payload   = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    pfa_pkg::out_item_t          m_payload;

    int mismatches;
    int pending;
    int checked;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int sent_count    = 0;
    int setting_count = 0;
    int stuck_cycles  = 0;

    // Moduli visited after the directed part: small and large primes, composites, degenerate
    logic [pfa_pkg::FIELD_W-1:0] moduli [NUM_MODULI] = '{
        31'd2, 31'd3, 31'd7, 31'd251, 31'd8191, 31'd65521, 31'd131071, 31'd1000003,
        31'd2147483629, 31'd15, 31'd2147483646, 31'd0, 31'd1, 31'd2147483647
    };

    prime_field_alu #(.WIDTH(pfa_pkg::FIELD_W)) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    pfa_scoreboard u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic pfa_pkg::in_item_t make_item(logic [pfa_pkg::CMD_W-1:0]   cmd,
                                                    logic [pfa_pkg::FIELD_W-1:0] a,
                                                    logic [pfa_pkg::FIELD_W-1:0] b,
                                                    logic [pfa_pkg::FIELD_W-1:0] c);
        pfa_pkg::in_item_t it;
        it.cmd  = cmd;
        it.op_a = a;
        it.op_b = b;
        it.op_c = c;
        return it;
    endfunction

    // Mostly residues, with zero, one, p-1, p itself and unreduced values mixed in
    function automatic logic [pfa_pkg::FIELD_W-1:0] random_operand(
        logic [pfa_pkg::FIELD_W-1:0] p);
        case ($urandom_range(9))
            0:       return '0;
            1:       return pfa_pkg::FIELD_W'(1);
            2:       return (p == '0) ? '0 : p - 1'b1;
            3:       return p;
            4, 5:    return pfa_pkg::FIELD_W'($urandom());
            6:       return ALL_ONES;
            default: begin
                return (p == '0) ? pfa_pkg::FIELD_W'($urandom())
                                 : pfa_pkg::FIELD_W'($urandom() % p);
            end
        endcase
    endfunction

    function automatic pfa_pkg::in_item_t random_item(logic [pfa_pkg::FIELD_W-1:0] p);
        logic [pfa_pkg::CMD_W-1:0] cmd;
        if ($urandom_range(31) == 0) begin
            cmd = CMD_UNUSED;
        end else begin
            cmd = pfa_pkg::CMD_W'($urandom_range(pfa_pkg::CMD_DIV, pfa_pkg::CMD_ADD));
        end
        return make_item(cmd, random_operand(p), random_operand(p), random_operand(p));
    endfunction

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_item(input pfa_pkg::in_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_modulus(input logic [pfa_pkg::FIELD_W-1:0] value);
        wait_until_idle();
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        setting_count++;
    endtask

    initial begin
        logic [pfa_pkg::FIELD_W-1:0] p;
        int                          n_items;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks under the reset modulus
        p = pfa_pkg::MOD_RESET;
        setting_count = 1;
        send_item(make_item(pfa_pkg::CMD_ADD,    p - 1'b1, p - 1'b1, '0));
        send_item(make_item(pfa_pkg::CMD_ADD,    ALL_ONES, 31'd5, ALL_ONES));
        send_item(make_item(pfa_pkg::CMD_ADD,    '0, '0, '0));
        send_item(make_item(pfa_pkg::CMD_SUB,    31'd3, 31'd10, '0));
        send_item(make_item(pfa_pkg::CMD_SUB,    '0, '0, ALL_ONES));
        send_item(make_item(pfa_pkg::CMD_NEG,    '0, ALL_ONES, '0));
        send_item(make_item(pfa_pkg::CMD_NEG,    31'd1, '0, '0));
        send_item(make_item(pfa_pkg::CMD_MUL,    p - 1'b1, p - 1'b1, '0));
        send_item(make_item(pfa_pkg::CMD_MUL,    '0, 31'h5A5A_A5A5, '0));
        send_item(make_item(pfa_pkg::CMD_MULSUB, '0, 31'd123, ALL_ONES));
        send_item(make_item(pfa_pkg::CMD_MULSUB, 31'd77, '0, 31'd12345));
        send_item(make_item(pfa_pkg::CMD_MULSUB, 31'd2, 31'd3, 31'd5));
        send_item(make_item(pfa_pkg::CMD_INV,    '0, '0, '0));
        send_item(make_item(pfa_pkg::CMD_INV,    31'd1, '0, '0));
        send_item(make_item(pfa_pkg::CMD_INV,    p - 1'b1, '0, '0));
        send_item(make_item(pfa_pkg::CMD_INV,    ALL_ONES, '0, '0));
        send_item(make_item(pfa_pkg::CMD_INV,    31'd2, '0, '0));
        send_item(make_item(pfa_pkg::CMD_DIV,    31'd9, '0, '0));
        send_item(make_item(pfa_pkg::CMD_DIV,    31'd9, ALL_ONES, '0));
        send_item(make_item(pfa_pkg::CMD_DIV,    '0, 31'd7, '0));
        send_item(make_item(pfa_pkg::CMD_DIV,    p - 1'b1, 31'd3, '0));
        send_item(make_item(CMD_UNUSED,          31'd5, 31'd6, 31'd7));

        // Random traffic under each modulus, rotating through the idle patterns
        for (int i = 0; i < NUM_MODULI; i++) begin
            p = moduli[i];
            write_modulus(p);
            case (i % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            if (p == '0) begin
                send_item(make_item(pfa_pkg::CMD_DIV, 31'd4, '0, '0));
                send_item(make_item(pfa_pkg::CMD_DIV, 31'd4, 31'd3, '0));
            end
            n_items = (p < 2) ? 30 : 100;
            for (int j = 0; j < n_items; j++) begin
                send_item(random_item(p));
            end
        end

        // Drain, let any stray result show up, then report
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d transactions over %0d modulus settings (0, 1, 2, composites, 2^31-1)",
                 sent_count, setting_count);
        $display("with all opcodes and idle patterns; %0d results checked, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
